// File: hw/rtl/sha256_byte_stream_hasher_defines.svh
// Assertion macros for the SHA-256 byte stream hasher RTL.
// Depends on nothing; files that assert include it by name.
// Each macro expects i_clk to be in scope; SBSH_ASSERT also expects i_rst_n.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside of reset.
`define SBSH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SBSH_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define SBSH_ASSERT(lbl, prop, msg)
`define SBSH_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// File: hw/rtl/sbsh_pkg.sv
// Shared types, constants and tables for the SHA-256 byte stream hasher.
// Depends on nothing; every RTL module of the block imports it.
package sbsh_pkg;

    // Padding and block bookkeeping.
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_FILL   = 6'd56;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LEN_LAST   = 3'd7;

    // Initial hash value, word 0 in the top bits.
    localparam logic [255:0] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants.
    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // One input request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } t_in_item;

    // One digest result.
    typedef struct packed {
        logic [63:0] digest_part_0;
        logic [63:0] digest_part_1;
        logic [63:0] digest_part_2;
        logic [63:0] digest_part_3;
    } t_out_item;

    // Commands from the sequencer to the compression datapath.
    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       load;
        logic       round;
        logic [5:0] round_idx;
        logic       fold;
        logic       init;
    } t_core_cmd;

endpackage

// File: hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: accepts message bytes and returns one digest per
// message. Instantiates sbsh_ctrl and sbsh_core; uses types from sbsh_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one request per
//   message byte. byte_present marks a real byte; last_byte closes the message.
//   A request with last_byte and no byte closes the message as it stands, so an
//   empty message is hashed by a single such request.
//   Output channel (o_out_valid / i_out_stall / o_out_item) carries the 256-bit
//   digest as four 64-bit parts, word 0 in the top half of digest_part_0.
// Sequence:
//   A byte that does not complete a block is taken with o_in_stall low. The
//   byte that fills a block raises o_in_stall while the single-round compression
//   unit runs 64 rounds and then folds the result into the chaining value.
//   A last request pushes the padding bytes (9 to 72) one at a time,
//   compresses each padded block (one or two) with rounds and a fold, then
//   moves the digest into the output register; o_in_stall stays high for all.
// Reset and stalls:
//   Reset loads the initial hash value and clears counters and the output
//   valid. A stalled digest holds in the output register; new bytes are taken
//   meanwhile, and only the next digest waits until the register frees up.
module sha256_byte_stream_hasher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sbsh_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sbsh_pkg::t_out_item o_out_item
);
    import sbsh_pkg::*;

    t_core_cmd    w_cmd;
    logic [255:0] w_digest;
    logic         w_out_free;
    logic         r_out_valid;
    t_out_item    r_out_item;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer.
    sbsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd)
    );

    // Compression datapath.
    sbsh_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_digest (w_digest)
    );

    // Output register: loaded when the sequencer hands over a digest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.init) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.init) begin
            r_out_item.digest_part_0 <= w_digest[255:192];
            r_out_item.digest_part_1 <= w_digest[191:128];
            r_out_item.digest_part_2 <= w_digest[127:64];
            r_out_item.digest_part_3 <= w_digest[63:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hw/rtl/sbsh_core.sv
// Compression datapath: block window, message schedule, one round per cycle.
// Depends on sbsh_pkg for the command struct, round constants and IV.
module sbsh_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbsh_pkg::t_core_cmd i_cmd,
    output logic [255:0]       o_digest
);
    import sbsh_pkg::*;

    function automatic logic [31:0] f_big0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_big1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    // The window holds the block bytes while filling and the sixteen newest
    // schedule words while compressing; word 0 sits in the top bits.
    logic [511:0] r_window;
    logic [31:0]  r_hash [8];
    logic [31:0]  r_var  [8];

    logic [31:0] w_w0;
    logic [31:0] w_w1;
    logic [31:0] w_w9;
    logic [31:0] w_w14;
    logic [31:0] w_sched;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    // Schedule taps and the next schedule word.
    assign w_w0    = r_window[511:480];
    assign w_w1    = r_window[479:448];
    assign w_w9    = r_window[223:192];
    assign w_w14   = r_window[63:32];
    assign w_sched = f_sig1(w_w14) + w_w9 + f_sig0(w_w1) + w_w0;

    // Round function.
    assign w_ch  = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
    assign w_maj = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
    assign w_t1  = r_var[7] + f_big1(r_var[4]) + w_ch + K_TABLE[i_cmd.round_idx] + w_w0;
    assign w_t2  = f_big0(r_var[0]) + w_maj;

    // Window: byte shift while filling, word shift while compressing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_window <= {r_window[503:0], i_cmd.push_data};
        end else if (i_cmd.round) begin
            r_window <= {r_window[479:0], w_sched};
        end
    end

    // Working variables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 8; i++) begin
                r_var[i] <= r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + w_t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= w_t1 + w_t2;
        end
    end

    // Chaining value: IV after reset or a digest, accumulated after a block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= HASH_IV[255 - 32 * i -: 32];
            end
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + r_var[i];
            end
        end
    end

    assign o_digest = {r_hash[0], r_hash[1], r_hash[2], r_hash[3],
                       r_hash[4], r_hash[5], r_hash[6], r_hash[7]};

endmodule

// File: hw/rtl/sbsh_ctrl.sv
// Sequencer: byte intake, padding, round counting and digest hand-off.
// Depends on sbsh_pkg and the assertion macros in the defines header.
`include "sha256_byte_stream_hasher_defines.svh"

module sbsh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  sbsh_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    input  logic                i_out_free,
    output sbsh_pkg::t_core_cmd o_cmd
);
    import sbsh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } t_phase;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    t_phase      r_phase, n_phase;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_count, n_count;
    logic [2:0]  r_len_idx, n_len_idx;
    logic [5:0]  r_round, n_round;

    logic [63:0] w_len_bits;
    logic [7:0]  w_len_byte;

    // Big-endian bit length, one byte picked per padding step.
    assign w_len_bits = {r_count, 3'b000};
    assign w_len_byte = w_len_bits[{~r_len_idx, 3'b111} -: 8];

    assign o_in_stall = (r_state != ST_IDLE);

    // Next-state and command decode.
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_phase   = r_phase;
        n_fill    = r_fill;
        n_count   = r_count;
        n_len_idx = r_len_idx;
        n_round   = r_round;
        o_cmd     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.byte_present) begin
                        o_cmd.push      = 1'b1;
                        o_cmd.push_data = i_in_item.data_byte;
                        n_count         = r_count + 61'd1;
                        n_fill          = r_fill + 6'd1;
                    end
                    if (i_in_item.last_byte) begin
                        n_phase   = PH_MARK;
                        n_len_idx = '0;
                        n_state   = ST_PAD;
                    end
                    // A full block goes to compression before padding starts.
                    if (i_in_item.byte_present && r_fill == LAST_FILL) begin
                        o_cmd.load = 1'b1;
                        n_round    = '0;
                        n_state    = ST_COMP;
                        n_ret      = i_in_item.last_byte ? ST_PAD : ST_IDLE;
                    end
                end
            end

            ST_PAD: begin
                o_cmd.push = 1'b1;
                n_fill     = r_fill + 6'd1;
                case (r_phase)
                    PH_MARK: begin
                        o_cmd.push_data = PAD_MARK;
                        n_phase         = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (r_fill == LEN_FILL) begin
                            o_cmd.push_data = w_len_byte;
                            n_phase         = PH_LEN;
                            n_len_idx       = r_len_idx + 3'd1;
                        end else begin
                            o_cmd.push_data = '0;
                        end
                    end
                    PH_LEN: begin
                        o_cmd.push_data = w_len_byte;
                        n_len_idx       = r_len_idx + 3'd1;
                    end
                    default: begin
                        o_cmd.push_data = '0;
                    end
                endcase
                // A padding byte that completes a block starts compression; the final length byte always does.
                if (r_fill == LAST_FILL) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_state    = ST_COMP;
                    n_ret      = (r_phase == PH_LEN && r_len_idx == LEN_LAST) ?
                                 ST_DONE : ST_PAD;
                end
            end

            ST_COMP: begin
                o_cmd.round     = 1'b1;
                o_cmd.round_idx = r_round;
                n_round         = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FIN;
                end
            end

            ST_FIN: begin
                o_cmd.fold = 1'b1;
                n_state    = r_ret;
            end

            ST_DONE: begin
                // Hand the digest over once the output register is free.
                if (i_out_free) begin
                    o_cmd.init = 1'b1;
                    n_count    = '0;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ret     <= ST_IDLE;
            r_phase   <= PH_MARK;
            r_fill    <= '0;
            r_count   <= '0;
            r_len_idx <= '0;
            r_round   <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_phase   <= n_phase;
            r_fill    <= n_fill;
            r_count   <= n_count;
            r_len_idx <= n_len_idx;
            r_round   <= n_round;
        end
    end

    `SBSH_ASSERT(a_comp_runs_all_rounds, (r_state == ST_COMP) && (r_round != LAST_ROUND) |=> r_state == ST_COMP, "compression left before the last round")
    `SBSH_ASSERT(a_fin_follows_comp, r_state == ST_FIN |-> $past(r_state) == ST_COMP, "fold without a preceding compression")
    `SBSH_ASSERT(a_done_block_aligned, r_state == ST_DONE |-> (r_fill == 6'd0) && (r_len_idx == 3'd0), "digest ready with a partial block")
    `SBSH_ASSERT_RST(a_reset_clears, !i_rst_n |=> (r_state == ST_IDLE) && (r_count == 61'd0), "reset did not clear the sequencer")

endmodule
